// ----- hw/rtl/assert_macros.svh -----
// ============================================================================
// assert_macros.svh: concurrent assertion helpers
// Short forms for implication checks clocked on clk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Implication after a fixed number of cycles.
`define ASSERT_AFTER(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("delayed check failed");

`endif

// ----- hw/rtl/qte_pkg.sv -----
// ============================================================================
// qte_pkg: shared types and arithmetic for the quintic trajectory evaluator
// Fixed-point formats, saturating helpers and the derivative weight table.
// ============================================================================
package qte_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IFRAC     = 32;
  localparam int INT_SHIFT = IFRAC - FRAC_BITS;
  localparam int ADDR_W    = 5;

  typedef logic signed [63:0] fx_t;

  localparam fx_t IMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic sat;
    fx_t  val;
  } fx_res_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SAT      = 2'd1,
    STATUS_DUR_ZERO = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_START_POS = 3'd0,
    REG_START_VEL = 3'd1,
    REG_START_ACC = 3'd2,
    REG_END_POS   = 3'd3,
    REG_END_VEL   = 3'd4,
    REG_END_ACC   = 3'd5,
    REG_DURATION  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] end_pos;
    logic signed [31:0] end_vel;
    logic signed [31:0] end_acc;
    logic [30:0]        duration;
  } cfg_regs_t;

  typedef struct packed {
    logic [5:0][63:0] coef;
    logic             sat;
  } coef_set_t;

  // One item moving down the evaluation pipeline.
  typedef struct packed {
    logic       valid;
    logic [2:0] order;
    logic       dur_zero;
    logic       sat;
    fx_t        p;
    fx_t        acc;
  } token_t;

  // k!/(k-n)! for derivative order n and coefficient index k.
  localparam logic [6:0] WEIGHT_TBL [6][6] = '{
    '{7'd1, 7'd1, 7'd1, 7'd1,  7'd1,  7'd1},
    '{7'd0, 7'd1, 7'd2, 7'd3,  7'd4,  7'd5},
    '{7'd0, 7'd0, 7'd2, 7'd6,  7'd12, 7'd20},
    '{7'd0, 7'd0, 7'd0, 7'd6,  7'd24, 7'd60},
    '{7'd0, 7'd0, 7'd0, 7'd0,  7'd24, 7'd120},
    '{7'd0, 7'd0, 7'd0, 7'd0,  7'd0,  7'd120}
  };

  function automatic logic [6:0] horner_weight(input logic [2:0] n, input logic [2:0] k);
    logic [6:0] w;
    w = '0;
    if (n <= 3'd5 && k <= 3'd5) w = WEIGHT_TBL[n][k];
    return w;
  endfunction

  function automatic logic [62:0] fx_mag(input fx_t a);
    logic [63:0] m;
    m = a[63] ? 64'(-a) : 64'(a);
    return m[62:0];
  endfunction

  function automatic fx_t fx_signed(input logic neg, input logic [62:0] m);
    fx_t mv;
    mv = {1'b0, m};
    return neg ? -mv : mv;
  endfunction

  function automatic fx_res_t fx_addsat(input fx_t a, input fx_t b, input logic sub);
    logic signed [64:0] s;
    logic signed [64:0] lim;
    fx_res_t r;
    lim = 65'(IMAX);
    s = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
    if (s > lim) begin
      r.sat = 1'b1;
      r.val = IMAX;
    end else if (s < -lim) begin
      r.sat = 1'b1;
      r.val = -IMAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[63:0];
    end
    return r;
  endfunction

  // Product magnitude in Q64.64 form, truncated to IFRAC fraction bits.
  function automatic fx_res_t fx_mul_fin(input logic neg, input logic [127:0] prod);
    fx_res_t r;
    r.sat = |prod[127:95];
    r.val = fx_signed(neg, r.sat ? IMAX[62:0] : prod[94:32]);
    return r;
  endfunction

  // Magnitude times a small integer weight.
  function automatic fx_res_t fx_mul_small(input fx_t a, input logic [6:0] w);
    logic [69:0] pr;
    fx_res_t r;
    pr = 70'(fx_mag(a)) * 70'(w);
    r.sat = |pr[69:63];
    r.val = fx_signed(a[63], r.sat ? IMAX[62:0] : pr[62:0]);
    return r;
  endfunction

  function automatic fx_res_t fx_div_fin(input logic neg, input logic [95:0] q);
    fx_res_t r;
    r.sat = |q[95:63];
    r.val = fx_signed(neg, r.sat ? IMAX[62:0] : q[62:0]);
    return r;
  endfunction

  function automatic fx_t fx_from_q(input logic signed [31:0] v);
    return fx_t'(v) <<< INT_SHIFT;
  endfunction

endpackage

// ----- hw/rtl/qte_coef_unit.sv -----
// ============================================================================
// qte_coef_unit: coefficient builder
// Microcoded sequencer with a shared multiplier and a bit-serial divider.
// ============================================================================
module qte_coef_unit import qte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      kick,
  input  cfg_regs_t cfg,
  output coef_set_t coefs,
  output logic      busy
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_READ, S_EXEC} state_t;
  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] dst;
    logic [4:0] srca;
    logic [4:0] srcb;
  } instr_t;

  localparam logic [4:0] R_X0 = 5'd0, R_V0 = 5'd1, R_C0 = 5'd2, R_X1 = 5'd3;
  localparam logic [4:0] R_V1 = 5'd4, R_C1 = 5'd5, R_P = 5'd6, R_T = 5'd7;
  localparam logic [4:0] R_U = 5'd8, R_K0 = 5'd9, R_K1 = 5'd10, R_K2 = 5'd11;
  localparam logic [4:0] R_CF2 = 5'd12, R_CF3 = 5'd13, R_CF4 = 5'd14, R_CF5 = 5'd15;
  localparam logic [4:0] K_HALF = 5'd16, K_20 = 5'd17, K_8 = 5'd18, K_M15 = 5'd19;
  localparam logic [4:0] K_7 = 5'd20, K_6 = 5'd21, K_3 = 5'd22;

  localparam int PROG_LEN = 35;
  localparam logic [6:0] MUL_LAST = 7'd4;
  localparam logic [6:0] DIV_LAST = 7'd97;

  localparam instr_t PROG [PROG_LEN] = '{
    '{OP_MUL, R_CF2, R_C0, K_HALF},
    '{OP_MUL, R_T, R_C0, R_P},
    '{OP_MUL, R_T, R_T, R_P},
    '{OP_MUL, R_T, R_T, K_HALF},
    '{OP_SUB, R_T, R_X1, R_T},
    '{OP_MUL, R_U, R_V0, R_P},
    '{OP_SUB, R_T, R_T, R_U},
    '{OP_SUB, R_T, R_T, R_X0},
    '{OP_DIV, R_T, R_T, R_P},
    '{OP_DIV, R_T, R_T, R_P},
    '{OP_DIV, R_K0, R_T, R_P},
    '{OP_MUL, R_T, R_C0, R_P},
    '{OP_SUB, R_T, R_V1, R_T},
    '{OP_SUB, R_T, R_T, R_V0},
    '{OP_DIV, R_T, R_T, R_P},
    '{OP_DIV, R_K1, R_T, R_P},
    '{OP_SUB, R_T, R_C1, R_C0},
    '{OP_DIV, R_K2, R_T, R_P},
    '{OP_MUL, R_T, R_K0, K_20},
    '{OP_MUL, R_U, R_K1, K_8},
    '{OP_SUB, R_T, R_T, R_U},
    '{OP_ADD, R_T, R_T, R_K2},
    '{OP_MUL, R_CF3, R_T, K_HALF},
    '{OP_MUL, R_T, R_K0, K_M15},
    '{OP_MUL, R_U, R_K1, K_7},
    '{OP_ADD, R_T, R_T, R_U},
    '{OP_SUB, R_T, R_T, R_K2},
    '{OP_DIV, R_CF4, R_T, R_P},
    '{OP_MUL, R_T, R_K0, K_6},
    '{OP_MUL, R_U, R_K1, K_3},
    '{OP_SUB, R_T, R_T, R_U},
    '{OP_MUL, R_U, R_K2, K_HALF},
    '{OP_ADD, R_T, R_T, R_U},
    '{OP_DIV, R_T, R_T, R_P},
    '{OP_DIV, R_CF5, R_T, R_P}
  };

  function automatic fx_t kconst(input logic [4:0] sel);
    fx_t k;
    unique case (sel)
      K_HALF:  k = 64'sh0000_0000_8000_0000;
      K_20:    k = fx_t'(20) <<< IFRAC;
      K_8:     k = fx_t'(8) <<< IFRAC;
      K_M15:   k = fx_t'(-15) <<< IFRAC;
      K_7:     k = fx_t'(7) <<< IFRAC;
      K_6:     k = fx_t'(6) <<< IFRAC;
      K_3:     k = fx_t'(3) <<< IFRAC;
      default: k = '0;
    endcase
    return k;
  endfunction

  state_t           state_r;
  logic [5:0]       pc_r;
  logic [6:0]       cnt_r;
  logic             sat_acc_r;
  logic [5:0][63:0] coef_r;
  logic             coef_sat_r;
  logic [127:0]     prod_r;
  logic [63:0]      rem_r;
  logic [95:0]      num_r;
  logic [95:0]      q_r;

  fx_t        mem [16];
  fx_t        rdata_a_r;
  fx_t        rdata_b_r;
  logic       mem_we;
  logic [3:0] mem_waddr;
  fx_t        mem_wdata;

  instr_t       ins;
  fx_t          opa;
  fx_t          opb;
  logic [62:0]  ma;
  logic [62:0]  mb;
  logic         neg;
  logic [31:0]  ah;
  logic [31:0]  bh;
  logic [63:0]  pp;
  logic [6:0]   sh;
  logic [127:0] prod_nxt;
  logic [64:0]  rtry;
  logic         ge;
  logic [63:0]  rem_nxt;
  fx_t          load_val;
  fx_res_t      res;
  logic         wr_op;
  logic         last_ins;

  assign ins = PROG[pc_r];
  assign opa = ins.srca[4] ? kconst(ins.srca) : rdata_a_r;
  assign opb = ins.srcb[4] ? kconst(ins.srcb) : rdata_b_r;
  assign ma  = fx_mag(opa);
  assign mb  = fx_mag(opb);
  assign neg = opa[63] ^ opb[63];

  // Four 32x32 partial products, one per cycle.
  assign ah       = cnt_r[1] ? {1'b0, ma[62:32]} : ma[31:0];
  assign bh       = cnt_r[0] ? {1'b0, mb[62:32]} : mb[31:0];
  assign pp       = 64'(ah) * 64'(bh);
  assign sh       = ({6'd0, cnt_r[1]} + {6'd0, cnt_r[0]}) << 5;
  assign prod_nxt = prod_r + (128'(pp) << sh);

  // Restoring division, one quotient bit per cycle.
  assign rtry    = {rem_r, num_r[95]};
  assign ge      = rtry >= {2'b00, mb};
  assign rem_nxt = ge ? 64'(rtry - {2'b00, mb}) : rtry[63:0];

  always_comb begin
    unique case (cnt_r[2:0])
      3'd0:    load_val = fx_from_q(cfg.start_pos);
      3'd1:    load_val = fx_from_q(cfg.start_vel);
      3'd2:    load_val = fx_from_q(cfg.start_acc);
      3'd3:    load_val = fx_from_q(cfg.end_pos);
      3'd4:    load_val = fx_from_q(cfg.end_vel);
      3'd5:    load_val = fx_from_q(cfg.end_acc);
      default: load_val = fx_t'({1'b0, cfg.duration}) <<< INT_SHIFT;
    endcase
  end

  always_comb begin
    res   = '0;
    wr_op = 1'b0;
    unique case (ins.op)
      OP_ADD: begin
        res   = fx_addsat(opa, opb, 1'b0);
        wr_op = 1'b1;
      end
      OP_SUB: begin
        res   = fx_addsat(opa, opb, 1'b1);
        wr_op = 1'b1;
      end
      OP_MUL: begin
        res   = fx_mul_fin(neg, prod_r);
        wr_op = (cnt_r == MUL_LAST);
      end
      OP_DIV: begin
        if (mb == '0) begin
          res.sat = 1'b1;
          res.val = neg ? -IMAX : IMAX;
        end else begin
          res = fx_div_fin(neg, q_r);
        end
        wr_op = (cnt_r == DIV_LAST);
      end
      default: begin
        res   = '0;
        wr_op = 1'b0;
      end
    endcase
  end

  assign last_ins = (pc_r == 6'(PROG_LEN - 1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ins.dst[3:0];
    mem_wdata = res.val;
    if (state_r == S_LOAD) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r[3:0];
      mem_wdata = load_val;
    end else if (state_r == S_EXEC) begin
      mem_we = wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_a_r <= mem[ins.srca[3:0]];
    rdata_b_r <= mem[ins.srcb[3:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pc_r       <= '0;
      cnt_r      <= '0;
      sat_acc_r  <= 1'b0;
      coef_r     <= '0;
      coef_sat_r <= 1'b0;
    end else if (kick) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      sat_acc_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
        end
        S_LOAD: begin
          if (cnt_r == 7'd0) coef_r[0] <= load_val;
          if (cnt_r == 7'd1) coef_r[1] <= load_val;
          if (cnt_r == 7'd6) begin
            state_r <= S_READ;
            pc_r    <= '0;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        S_READ: begin
          state_r <= S_EXEC;
          cnt_r   <= '0;
        end
        S_EXEC: begin
          if (ins.op == OP_MUL) begin
            prod_r <= (cnt_r == 7'd0) ? 128'(pp) : prod_nxt;
          end
          if (ins.op == OP_DIV) begin
            if (cnt_r == 7'd0) begin
              rem_r <= '0;
              num_r <= {1'b0, ma, 32'd0};
              q_r   <= '0;
            end else begin
              rem_r <= rem_nxt;
              num_r <= {num_r[94:0], 1'b0};
              q_r   <= {q_r[94:0], ge};
            end
          end
          if (wr_op) begin
            sat_acc_r <= sat_acc_r | res.sat;
            for (int k = 2; k < 6; k++) begin
              if (ins.dst == R_CF2 + 5'(k - 2)) coef_r[k] <= res.val;
            end
            if (last_ins) begin
              state_r    <= S_IDLE;
              coef_sat_r <= sat_acc_r | res.sat;
            end else begin
              pc_r    <= pc_r + 6'd1;
              state_r <= S_READ;
            end
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign coefs.coef = coef_r;
  assign coefs.sat  = coef_sat_r;
  assign busy       = (state_r != S_IDLE);

endmodule

// ----- hw/rtl/qte_horner_step.sv -----
// ============================================================================
// qte_horner_step: one Horner step, acc = acc * p + w * coef
// Stage A forms partial products and the weighted coefficient; stage B sums.
// ============================================================================
module qte_horner_step import qte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] step_k,
  input  fx_t        coef_k,
  input  token_t     tok_i,
  output token_t     tok_o
);

  token_t      a_tok_r;
  logic [63:0] pp0_r;
  logic [63:0] pp1_r;
  logic [63:0] pp2_r;
  logic [63:0] pp3_r;
  logic        neg_r;
  logic        active_r;
  fx_res_t     wc_r;
  token_t      b_tok_r;
  token_t      b_tok_nxt;

  logic [62:0]  ma;
  logic [62:0]  mp;
  logic [31:0]  a_lo;
  logic [31:0]  a_hi;
  logic [31:0]  p_lo;
  logic [31:0]  p_hi;
  logic [127:0] prod;
  fx_res_t      mul;
  fx_res_t      sum;

  assign ma   = fx_mag(tok_i.acc);
  assign mp   = fx_mag(tok_i.p);
  assign a_lo = ma[31:0];
  assign a_hi = {1'b0, ma[62:32]};
  assign p_lo = mp[31:0];
  assign p_hi = {1'b0, mp[62:32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tok_r.valid <= 1'b0;
    end else begin
      a_tok_r <= tok_i;
    end
    pp0_r    <= 64'(a_lo) * 64'(p_lo);
    pp1_r    <= 64'(a_lo) * 64'(p_hi);
    pp2_r    <= 64'(a_hi) * 64'(p_lo);
    pp3_r    <= 64'(a_hi) * 64'(p_hi);
    neg_r    <= tok_i.acc[63] ^ tok_i.p[63];
    active_r <= (tok_i.order <= step_k);
    wc_r     <= fx_mul_small(coef_k, horner_weight(tok_i.order, step_k));
  end

  assign prod = 128'(pp0_r) + (128'(pp1_r) << 32) + (128'(pp2_r) << 32)
              + (128'(pp3_r) << 64);
  assign mul  = fx_mul_fin(neg_r, prod);
  assign sum  = fx_addsat(mul.val, wc_r.val, 1'b0);

  // Steps below the requested order pass the token through untouched.
  always_comb begin
    b_tok_nxt = a_tok_r;
    if (active_r) begin
      b_tok_nxt.acc = sum.val;
      b_tok_nxt.sat = a_tok_r.sat | mul.sat | wc_r.sat | sum.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tok_r.valid <= 1'b0;
    end else begin
      b_tok_r <= b_tok_nxt;
    end
  end

  assign tok_o = b_tok_r;

endmodule

// ----- hw/rtl/qte_eval_pipe.sv -----
// ============================================================================
// qte_eval_pipe: derivative evaluation pipeline
// Input capture, leading term, five Horner steps and output truncation.
// ============================================================================
module qte_eval_pipe import qte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_order,
  input  logic signed [31:0] in_point,
  input  logic               dur_zero,
  input  coef_set_t          coefs,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status
);

  localparam logic [46:0] POS_LIM = 47'h0000_7FFF_FFFF;
  localparam logic [46:0] NEG_LIM = 47'h0000_8000_0000;

  token_t t0_r;
  token_t t1_r;
  token_t t1_nxt;
  token_t chain [6];

  fx_res_t lead;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_r.valid <= 1'b0;
    end else begin
      t0_r <= '{valid: in_valid, order: in_order, dur_zero: dur_zero, sat: 1'b0,
                p: fx_from_q(in_point), acc: '0};
    end
  end

  assign lead = fx_mul_small(fx_t'(coefs.coef[5]), horner_weight(t0_r.order, 3'd5));

  always_comb begin
    t1_nxt     = t0_r;
    t1_nxt.acc = lead.val;
    t1_nxt.sat = lead.sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r.valid <= 1'b0;
    end else begin
      t1_r <= t1_nxt;
    end
  end

  assign chain[0] = t1_r;

  for (genvar i = 0; i < 5; i++) begin : g_step
    qte_horner_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .step_k (3'(4 - i)),
      .coef_k (fx_t'(coefs.coef[4 - i])),
      .tok_i  (chain[i]),
      .tok_o  (chain[i + 1])
    );
  end

  token_t      fin;
  logic        neg;
  logic [46:0] m;
  logic [46:0] mc;
  logic        clamp;
  logic [31:0] val;
  status_t     status;

  assign fin = chain[5];
  assign neg = fin.acc[63];
  assign m   = 47'(fx_mag(fin.acc) >> INT_SHIFT);

  always_comb begin
    clamp = 1'b0;
    mc    = m;
    if (neg && m > NEG_LIM) begin
      clamp = 1'b1;
      mc    = NEG_LIM;
    end else if (!neg && m > POS_LIM) begin
      clamp = 1'b1;
      mc    = POS_LIM;
    end
    priority if (fin.dur_zero) begin
      val    = '0;
      status = STATUS_DUR_ZERO;
    end else if (fin.order > 3'd5) begin
      val    = '0;
      status = STATUS_OK;
    end else begin
      val    = neg ? 32'(-mc) : mc[31:0];
      status = (fin.sat | clamp | coefs.sat) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid  <= fin.valid;
      out_value  <= val;
      out_status <= status;
    end
  end

endmodule

// ----- hw/rtl/quintic_trajectory_evaluator_core.sv -----
// ============================================================================
// quintic_trajectory_evaluator_core: quintic trajectory derivative evaluator
// out_strobe pulses once for each start that is taken; one transfer per cycle
// while busy is low. A register write raises busy until the shared divider
// and multiplier have rebuilt the coefficients. rst_n is synchronous.
// ============================================================================
`include "assert_macros.svh"

// The block splits into three parts. The register file behind the APB-style
// port holds the boundary conditions and the segment duration. Every write
// restarts the coefficient unit, a small sequencer that runs the closed-form
// solution through one shared 32x32 multiplier (four passes per product) and
// a divider that retires one quotient bit per cycle; busy stays high until it
// finishes. The evaluation pipeline then takes one item per cycle while busy
// is low: a capture stage, a leading-term stage, five two-stage Horner steps
// and an output stage that truncates to Q16.16, clamps and forms the status.
// The receiver cannot stall, so the pipeline never holds and valid bits simply
// move with the data. Reset restores the register defaults (duration 1.0, all
// else zero), whose coefficients are all zero, and empties the pipeline.
module quintic_trajectory_evaluator_core import qte_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // Command channel.
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_deriv_order,
  input  logic signed [31:0]  in_eval_point,
  // Result channel, a one-cycle strobe per transfer.
  output logic                out_strobe,
  output logic signed [31:0]  out_value,
  output logic [1:0]          out_status,
  // Register port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [30:0] DUR_RESET = 31'(1) << FRAC_BITS;

  cfg_regs_t cfg_r;
  logic      wr_en;
  reg_idx_t  wr_idx;
  coef_set_t coefs;
  logic      coef_busy;
  logic      accept;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wr_idx = reg_idx_t'(paddr[4:2]);

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_regs_t'({192'd0, DUR_RESET});
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_START_POS: cfg_r.start_pos <= pwdata;
        REG_START_VEL: cfg_r.start_vel <= pwdata;
        REG_START_ACC: cfg_r.start_acc <= pwdata;
        REG_END_POS:   cfg_r.end_pos   <= pwdata;
        REG_END_VEL:   cfg_r.end_vel   <= pwdata;
        REG_END_ACC:   cfg_r.end_acc   <= pwdata;
        REG_DURATION:  cfg_r.duration  <= pwdata[30:0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_START_POS: prdata = cfg_r.start_pos;
      REG_START_VEL: prdata = cfg_r.start_vel;
      REG_START_ACC: prdata = cfg_r.start_acc;
      REG_END_POS:   prdata = cfg_r.end_pos;
      REG_END_VEL:   prdata = cfg_r.end_vel;
      REG_END_ACC:   prdata = cfg_r.end_acc;
      REG_DURATION:  prdata = {1'b0, cfg_r.duration};
      default:       prdata = '0;
    endcase
  end

  // The coefficient unit restarts on every register write.
  qte_coef_unit u_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .kick  (wr_en),
    .cfg   (cfg_r),
    .coefs (coefs),
    .busy  (coef_busy)
  );

  assign busy   = coef_busy;
  assign accept = start & ~coef_busy;

  qte_eval_pipe u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .in_order   (in_deriv_order),
    .in_point   (in_eval_point),
    .dur_zero   (cfg_r.duration == '0),
    .coefs      (coefs),
    .out_valid  (out_strobe),
    .out_value  (out_value),
    .out_status (out_status)
  );

  // Every accepted command produces a result once it has passed through the pipeline.
  `ASSERT_AFTER(a_result_latency, accept, 13, out_strobe)
  // A register write always starts a coefficient rebuild.
  `ASSERT_NEXT(a_write_sets_busy, wr_en, busy)
  // A zero duration result always carries a zero value.
  `ASSERT_IMPLIES(a_dur_zero_value, out_strobe && out_status == STATUS_DUR_ZERO, out_value == 0)

endmodule
